// ----- design/swhsr_pkg.sv -----
// Shared types and constants for the single-wire humidity sensor reader.
package swhsr_pkg;

    localparam int FRAME_BITS = 40;
    localparam int COUNT_W    = 16;
    localparam int TIMEOUT_W  = 12;
    localparam int INDEX_W    = $clog2(FRAME_BITS + 1);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Frame layout, MSB first: humidity, temperature, check byte
    localparam int HUM_LSB   = 24;
    localparam int TEMP_LSB  = 8;
    localparam int CHECK_LSB = 0;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESP_LOW_TO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_TO      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LOW_TO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_HIGH_TO   = 3'd5;

    // Register reset values
    localparam logic [COUNT_W-1:0]   RST_START_LOW     = 16'd2000;
    localparam logic [TIMEOUT_W-1:0] RST_RESP_LOW_TO   = 12'd200;
    localparam logic [TIMEOUT_W-1:0] RST_PHASE_TO      = 12'd100;
    localparam logic [TIMEOUT_W-1:0] RST_BIT_LOW_TO    = 12'd70;
    localparam logic [TIMEOUT_W-1:0] RST_ONE_THRESHOLD = 12'd40;
    localparam logic [TIMEOUT_W-1:0] RST_BIT_HIGH_TO   = 12'd80;

    // Operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUSY    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_RESP_END,
        PH_BIT_LOW,
        PH_BIT_HIGH
    } phase_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   start_low_ticks;
        logic [TIMEOUT_W-1:0] response_low_timeout;
        logic [TIMEOUT_W-1:0] phase_timeout;
        logic [TIMEOUT_W-1:0] bit_low_timeout;
        logic [TIMEOUT_W-1:0] one_threshold;
        logic [TIMEOUT_W-1:0] bit_high_timeout;
    } cfg_t;

    typedef struct packed {
        logic               drive_low;
        logic               done_res;
        logic [1:0]         status;
        logic [15:0]        humidity;
        logic signed [15:0] temperature;
        logic [7:0]         check_byte;
    } res_t;

endpackage

// ----- design/swhsr_cfg.sv -----
// Configuration register bank of the sensor reader.
module swhsr_cfg
    import swhsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_LOW:     cfg_next.start_low_ticks      = cfg_data;
                REG_RESP_LOW_TO:   cfg_next.response_low_timeout = cfg_data[TIMEOUT_W-1:0];
                REG_PHASE_TO:      cfg_next.phase_timeout        = cfg_data[TIMEOUT_W-1:0];
                REG_BIT_LOW_TO:    cfg_next.bit_low_timeout      = cfg_data[TIMEOUT_W-1:0];
                REG_ONE_THRESHOLD: cfg_next.one_threshold        = cfg_data[TIMEOUT_W-1:0];
                REG_BIT_HIGH_TO:   cfg_next.bit_high_timeout     = cfg_data[TIMEOUT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks      <= RST_START_LOW;
            cfg_reg.response_low_timeout <= RST_RESP_LOW_TO;
            cfg_reg.phase_timeout        <= RST_PHASE_TO;
            cfg_reg.bit_low_timeout      <= RST_BIT_LOW_TO;
            cfg_reg.one_threshold        <= RST_ONE_THRESHOLD;
            cfg_reg.bit_high_timeout     <= RST_BIT_HIGH_TO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- design/swhsr_core.sv -----
// Exchange sequencer: phase machine, tick counter, bit shifter and result build.
module swhsr_core
    import swhsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  logic operation,
    input  logic line_level,
    input  cfg_t cfg,
    output res_t res
);

    phase_t                phase_reg, phase_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic                  drive_reg, drive_next;

    logic                  fin;
    logic [1:0]            fin_status;

    logic [COUNT_W-1:0]    cnt_inc;
    logic                  start_end;
    logic                  resp_low_to;
    logic                  phase_to;
    logic                  bit_low_to;
    logic                  bit_high_to;
    logic                  bit_val;
    logic                  last_bit;
    logic [15:0]           temp_word;
    logic [15:0]           temp_mag;

    // Saturating tick count
    assign cnt_inc     = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign start_end   = (cnt_inc >= cfg.start_low_ticks) || (cnt_inc == COUNT_MAX);
    assign resp_low_to = cnt_inc > COUNT_W'(cfg.response_low_timeout);
    assign phase_to    = cnt_inc > COUNT_W'(cfg.phase_timeout);
    assign bit_low_to  = cnt_inc > COUNT_W'(cfg.bit_low_timeout);
    assign bit_high_to = cnt_inc > COUNT_W'(cfg.bit_high_timeout);
    assign bit_val     = count_reg > COUNT_W'(cfg.one_threshold);
    assign last_bit    = index_reg == INDEX_W'(FRAME_BITS - 1);

    // Next phase and end of reading
    always_comb
    begin
        phase_next = phase_reg;
        fin        = 1'b0;
        fin_status = ST_OK;
        if (accept)
        begin
            if (operation == OP_START)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    if (!line_level)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_BUSY;
                    end
                    else
                    begin
                        phase_next = PH_START;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        phase_next = PH_IDLE;
                    end
                    PH_START:
                    begin
                        if (start_end)
                            phase_next = PH_RESP_LOW;
                    end
                    PH_RESP_LOW:
                    begin
                        if (!line_level)
                            phase_next = PH_RESP_HIGH;
                        else if (resp_low_to)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_TIMEOUT;
                        end
                    end
                    PH_RESP_HIGH:
                    begin
                        if (line_level)
                            phase_next = PH_RESP_END;
                        else if (phase_to)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_TIMEOUT;
                        end
                    end
                    PH_RESP_END:
                    begin
                        if (!line_level)
                            phase_next = PH_BIT_LOW;
                        else if (phase_to)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_TIMEOUT;
                        end
                    end
                    PH_BIT_LOW:
                    begin
                        if (line_level)
                            phase_next = PH_BIT_HIGH;
                        else if (bit_low_to)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_TIMEOUT;
                        end
                    end
                    PH_BIT_HIGH:
                    begin
                        if (line_level)
                        begin
                            if (bit_high_to)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_TIMEOUT;
                            end
                        end
                        else if (last_bit)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_OK;
                        end
                        else
                        begin
                            phase_next = PH_BIT_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            if (fin)
                phase_next = PH_IDLE;
        end
    end

    // Datapath and result word
    always_comb
    begin
        count_next = count_reg;
        index_next = index_reg;
        shift_next = shift_reg;
        drive_next = drive_reg;
        if (accept)
        begin
            if (operation == OP_START)
            begin
                if (phase_reg == PH_IDLE && line_level)
                begin
                    shift_next = '0;
                    index_next = '0;
                    drive_next = 1'b1;
                    count_next = '0;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_START:
                    begin
                        count_next = start_end ? '0 : cnt_inc;
                        if (start_end)
                            drive_next = 1'b0;
                    end
                    PH_RESP_LOW, PH_RESP_END:
                    begin
                        count_next = line_level ? cnt_inc : '0;
                    end
                    PH_RESP_HIGH:
                    begin
                        count_next = line_level ? '0 : cnt_inc;
                    end
                    PH_BIT_LOW:
                    begin
                        count_next = line_level ? COUNT_W'(1) : cnt_inc;
                    end
                    PH_BIT_HIGH:
                    begin
                        if (line_level)
                            count_next = cnt_inc;
                        else
                        begin
                            shift_next = {shift_reg[FRAME_BITS-2:0], bit_val};
                            index_next = index_reg + 1'b1;
                            count_next = '0;
                        end
                    end
                    default:
                    begin
                        count_next = count_reg;
                    end
                endcase
            end
            if (fin)
            begin
                count_next = '0;
                index_next = '0;
                drive_next = 1'b0;
            end
        end

        temp_word = shift_next[TEMP_LSB +: 16];
        temp_mag  = {1'b0, temp_word[14:0]};

        res.drive_low   = drive_next;
        res.done_res    = fin;
        res.status      = fin ? fin_status : ST_OK;
        res.humidity    = '0;
        res.temperature = '0;
        res.check_byte  = '0;
        if (fin && fin_status == ST_OK)
        begin
            res.humidity    = shift_next[HUM_LSB +: 16];
            // Sign-magnitude to two's complement; negative zero comes out as zero
            res.temperature = temp_word[15] ? $signed(-temp_mag) : $signed(temp_mag);
            res.check_byte  = shift_next[CHECK_LSB +: 8];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
            index_reg <= '0;
            shift_reg <= '0;
            drive_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            index_reg <= index_next;
            shift_reg <= shift_next;
            drive_reg <= drive_next;
        end
    end

endmodule

// ----- design/swhsr_outq.sv -----
// Two-entry result register with skid slot.
module swhsr_outq
    import swhsr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_word,
    output logic full,
    output logic out_valid,
    input  logic out_stall,
    output res_t head
);

    logic [1:0] cnt_reg, cnt_next;
    res_t       slot0_reg, slot0_next;
    res_t       slot1_reg, slot1_next;
    logic       pop;

    assign out_valid = cnt_reg != 2'd0;
    assign full      = cnt_reg == 2'd2;
    assign pop       = out_valid && !out_stall;
    assign head      = slot0_reg;

    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case ({push, pop})
            2'b10:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 2'd0)
                    slot0_next = push_word;
                else
                    slot1_next = push_word;
            end
            2'b01:
            begin
                cnt_next   = cnt_reg - 1'b1;
                slot0_next = slot1_reg;
            end
            2'b11:
            begin
                // Drain head and append in the same cycle
                if (cnt_reg == 2'd1)
                    slot0_next = push_word;
                else
                begin
                    slot0_next = slot1_reg;
                    slot1_next = push_word;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

// ----- design/single_wire_humidity_sensor_reader.sv -----
// Top level of the single-wire humidity and temperature sensor reader.
//
// Input channel (in_valid / in_stall): one word per microsecond tick with the
// sampled line level, or a start request. Output channel (out_valid /
// out_stall): exactly one result word per input word, in order, carrying the
// open-drain drive level, done flag, status and the decoded reading.
// Configuration: cfg_we writes cfg_data into the register at cfg_index.
// A result is formed as its input word is taken and is registered in the
// output register before it is presented. Throughput: one word per cycle
// while in_stall is low; the sequencer updates its state in the same cycle it
// takes a word, and the result lands in a two-entry output register.
// When the receiver stalls, results pile up in the two entries; in_stall
// rises once both are held and falls as soon as one is taken.
// Reset: phase idle, line released, counters cleared, output empty and
// registers at their default values.
module single_wire_humidity_sensor_reader
    import swhsr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  operation,
    input  logic                  line_level,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  drive_low,
    output logic                  done_res,
    output logic [1:0]            status,
    output logic [15:0]           humidity,
    output logic signed [15:0]    temperature,
    output logic [7:0]            check_byte
);

    cfg_t cfg;
    res_t res;
    res_t head;
    logic full;
    logic accept;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    swhsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swhsr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .line_level (line_level),
        .cfg        (cfg),
        .res        (res)
    );

    swhsr_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign drive_low   = head.drive_low;
    assign done_res    = head.done_res;
    assign status      = head.status;
    assign humidity    = head.humidity;
    assign temperature = head.temperature;
    assign check_byte  = head.check_byte;

endmodule
